// ----- src/stws_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stws_pkg
// Shared constants and types of the sliding time-window statistics block.
// ----------------------------------------------------------------------------
package stws_pkg;

    localparam int NUM_FIELDS   = 8;
    localparam int RING_DEPTH   = 256;
    localparam int FIELD_W      = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int CNT_W        = $clog2(RING_DEPTH + 1);
    localparam int ADDR_W       = FIELD_W + PTR_W;
    localparam int MEM_DEPTH    = NUM_FIELDS * RING_DEPTH;
    localparam int WIN_W        = 12;
    localparam int VAL_W        = 32;
    localparam int TS_W         = 64;
    localparam int OUT_CNT_W    = 9;
    localparam int SUM_W        = VAL_W + CNT_W + 1;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 12'd5;
    localparam logic [31:0]      NS_PER_SECOND = 32'd1000000000;

    typedef struct packed {
        logic [2:0]        field_index;
        logic signed [31:0] sample_value;
        logic [63:0]       timestamp_ns;
    } stws_in_t;

    typedef struct packed {
        logic signed [31:0] window_min;
        logic signed [31:0] window_max;
        logic signed [31:0] window_mean;
        logic signed [31:0] latest_value;
        logic [8:0]         entry_count;
        logic               ring_overflow;
    } stws_out_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [SUM_W-1:0]  quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_EXP_RD,
        ST_EXP_WAIT,
        ST_EXP_CHK,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_DIV,
        ST_OUT
    } stws_state_t;

endpackage
`default_nettype wire

// ----- src/stws_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stws_in_if / stws_out_if
// Valid/ready channels for input samples and result transactions.
// ----------------------------------------------------------------------------
interface stws_in_if;
    logic                      valid;
    logic                      ready;
    stws_pkg::stws_in_t        data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stws_out_if;
    logic                      valid;
    logic                      ready;
    stws_pkg::stws_out_t       data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/stws_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stws_div
// Restoring serial divider, one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module stws_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stws_pkg::div_req_t req,
    output stws_pkg::div_rsp_t     rsp
);
    import stws_pkg::*;

    localparam int BIT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] quo_next;
    logic [CNT_W:0]   rem_reg;
    logic [CNT_W:0]   rem_next;
    logic [CNT_W-1:0] dvs_reg;
    logic [CNT_W-1:0] dvs_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            bit_next  = BIT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            bit_next = bit_reg - 1'b1;
            if (bit_reg == BIT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// ----- src/sliding_time_window_stats.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_time_window_stats
// Per-field sliding time-window min, max, mean and latest value.
// ----------------------------------------------------------------------------
// One sample transaction at a time. The block writes the sample and then checks
// the oldest entries for expiry, one at a time. It scans the remaining window
// for min, max and sum, and divides the sum by the count in a serial divider.
// A full ring drops its oldest entry to make room for the new sample. A result
// stays in an output register until taken; while it waits, the next result
// holds the block in its last state. A field_index beyond the field count is
// taken and dropped with no result.
module sliding_time_window_stats
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [11:0]       cfg_wdata,
    stws_in_if.sink                in_ch,
    stws_out_if.source             out_ch
);
    import stws_pkg::*;

    logic signed [VAL_W-1:0] val_mem [MEM_DEPTH];
    logic [TS_W-1:0]         ts_mem  [MEM_DEPTH];

    logic [PTR_W-1:0] oldest_reg [NUM_FIELDS];
    logic [CNT_W-1:0] held_reg   [NUM_FIELDS];

    stws_state_t              state_reg, state_next;
    logic [WIN_W-1:0]         win_reg;
    logic [FIELD_W-1:0]       fld_reg;
    logic signed [VAL_W-1:0]  smp_reg;
    logic [TS_W-1:0]          ts_reg;
    logic [TS_W-1:0]          wns_reg;
    logic [PTR_W-1:0]         optr_reg, optr_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [PTR_W-1:0]         sptr_reg, sptr_next;
    logic [CNT_W-1:0]         left_reg, left_next;
    logic                     ovf_reg, ovf_next;
    logic signed [VAL_W-1:0]  mn_reg, mn_next, mx_reg, mx_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     first_reg, first_next;
    logic signed [VAL_W-1:0]  rdv_reg;
    logic [TS_W-1:0]          rdt_reg;
    stws_out_t                res_reg;
    logic                     ovalid_reg;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     wr_en;
    logic                     commit;
    logic                     set_out;
    logic                     accept;
    logic [PTR_W:0]           wpos;
    div_req_t                 dreq;
    div_rsp_t                 drsp;
    logic [SUM_W-1:0]         mag;
    logic [SUM_W-1:0]         qmag;
    logic [TS_W-1:0]          age;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            val_mem[wr_addr] <= smp_reg;
            ts_mem[wr_addr]  <= ts_reg;
        end
        rdv_reg <= val_mem[rd_addr];
        rdt_reg <= ts_mem[rd_addr];
    end

    stws_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign qmag = sum_reg[SUM_W-1] ? SUM_W'(-drsp.quotient) : drsp.quotient;
    assign age  = ts_reg - rdt_reg;

    always_comb
    begin
        state_next = state_reg;
        optr_next  = optr_reg;
        cnt_next   = cnt_reg;
        sptr_next  = sptr_reg;
        left_next  = left_reg;
        ovf_next   = ovf_reg;
        mn_next    = mn_reg;
        mx_next    = mx_reg;
        sum_next   = sum_reg;
        first_next = first_reg;
        wr_en      = 1'b0;
        commit     = 1'b0;
        set_out    = 1'b0;
        rd_addr    = {fld_reg, optr_reg};
        wpos       = '0;
        wr_addr    = '0;
        dreq       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (32'(in_ch.data.field_index) < 32'(NUM_FIELDS))
                    begin
                        state_next = ST_WRITE;
                        optr_next  = oldest_reg[FIELD_W'(in_ch.data.field_index)];
                        cnt_next   = held_reg[FIELD_W'(in_ch.data.field_index)];
                        ovf_next   = 1'b0;
                    end
                end
            end
            ST_WRITE:
            begin
                if (cnt_reg >= CNT_W'(RING_DEPTH))
                begin
                    optr_next = (optr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : optr_reg + 1'b1;
                    cnt_next  = CNT_W'(RING_DEPTH - 1);
                    ovf_next  = 1'b1;
                end
                else
                begin
                    wpos = (PTR_W+1)'(optr_reg) + (PTR_W+1)'(cnt_reg);
                    if (wpos >= (PTR_W+1)'(RING_DEPTH))
                        wpos = wpos - (PTR_W+1)'(RING_DEPTH);
                    wr_addr    = {fld_reg, wpos[PTR_W-1:0]};
                    wr_en      = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_EXP_RD;
                end
            end
            ST_EXP_RD:
            begin
                state_next = ST_EXP_WAIT;
            end
            ST_EXP_WAIT:
            begin
                state_next = ST_EXP_CHK;
            end
            ST_EXP_CHK:
            begin
                if (cnt_reg != '0 && rdt_reg < ts_reg && age > wns_reg)
                begin
                    optr_next  = (optr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : optr_reg + 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_EXP_RD;
                end
                else
                begin
                    commit     = 1'b1;
                    sptr_next  = optr_reg;
                    left_next  = cnt_reg;
                    sum_next   = '0;
                    first_next = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                rd_addr = {fld_reg, sptr_reg};
                if (left_reg == '0)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = mag;
                    dreq.divisor  = cnt_reg;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_SCAN_ACC;
            end
            ST_SCAN_ACC:
            begin
                rd_addr = {fld_reg, sptr_reg};
                if (first_reg || rdv_reg < mn_reg) mn_next = rdv_reg;
                if (first_reg || rdv_reg > mx_reg) mx_next = rdv_reg;
                sum_next   = sum_reg + SUM_W'(rdv_reg);
                first_next = 1'b0;
                sptr_next  = (sptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : sptr_reg + 1'b1;
                left_next  = left_reg - 1'b1;
                state_next = ST_SCAN_RD;
            end
            ST_DIV:
            begin
                if (drsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    set_out    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            win_reg    <= WINDOW_RESET;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                oldest_reg[i] <= '0;
                held_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                win_reg <= cfg_wdata;
            if (commit)
            begin
                oldest_reg[fld_reg] <= optr_reg;
                held_reg[fld_reg]   <= cnt_reg;
            end
            if (set_out)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fld_reg <= FIELD_W'(in_ch.data.field_index);
            smp_reg <= in_ch.data.sample_value;
            ts_reg  <= in_ch.data.timestamp_ns;
            wns_reg <= TS_W'(win_reg) * TS_W'(NS_PER_SECOND);
        end
        optr_reg  <= optr_next;
        cnt_reg   <= cnt_next;
        sptr_reg  <= sptr_next;
        left_reg  <= left_next;
        ovf_reg   <= ovf_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        sum_reg   <= sum_next;
        first_reg <= first_next;
        if (set_out)
        begin
            res_reg.window_min    <= mn_reg;
            res_reg.window_max    <= mx_reg;
            res_reg.window_mean   <= VAL_W'(qmag);
            res_reg.latest_value  <= smp_reg;
            res_reg.entry_count   <= OUT_CNT_W'(cnt_reg);
            res_reg.ring_overflow <= ovf_reg;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = res_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN_RD |-> cnt_reg <= CNT_W'(RING_DEPTH) && cnt_reg != '0)
        else $error("window count out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result dropped");

endmodule
`default_nettype wire
